// ===== hw/rtl/linear_probe_hash_table_defines.svh =====
// Assertion macros used by the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define LPHT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define LPHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lpht_pkg.sv =====
`timescale 1ns / 1ps
package lpht_pkg;
   localparam int unsigned REQ_TYPE_W = 3;
   localparam int unsigned HASH_W     = 64;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned COUNT_W    = 11;
   localparam int unsigned SIZE_LOG_W = 4;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 11;

   localparam logic [REQ_TYPE_W-1:0] OP_GET     = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_PUT     = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_REPLACE = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_ADD     = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_REMOVE  = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_USED_LIMIT = 1'd1;

   localparam logic [SIZE_LOG_W-1:0] SIZE_LOG_RESET   = 4'd10;
   localparam logic [COUNT_W-1:0]    USED_LIMIT_RESET = 11'd768;
   localparam logic [SIZE_LOG_W-1:0] SIZE_LOG_MIN     = 4'd3;
endpackage

// ===== hw/rtl/lpht_req_if.sv =====
`timescale 1ns / 1ps
interface lpht_req_if;
   import lpht_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [HASH_W-1:0]     key_hash;
   logic [VALUE_W-1:0]    new_value;
   modport source (output valid, req_type, key_hash, new_value, input ready);
   modport sink (input valid, req_type, key_hash, new_value, output ready);
endinterface

// ===== hw/rtl/lpht_rsp_if.sv =====
`timescale 1ns / 1ps
interface lpht_rsp_if;
   import lpht_pkg::*;
   logic               valid;
   logic               ready;
   logic               found;
   logic [VALUE_W-1:0] old_value;
   logic               add_done;
   logic               status;
   logic [COUNT_W-1:0] live_count;
   modport source (output valid, found, old_value, add_done, status, live_count, input ready);
   modport sink (input valid, found, old_value, add_done, status, live_count, output ready);
endinterface

// ===== hw/rtl/lpht_ram.sv =====
`timescale 1ns / 1ps
module lpht_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
`timescale 1ns / 1ps
// Open-addressed hash table with linear probing over one bucket memory. A request passes
// from the idle state through a read state and a check state for each bucket probed,
// starting at the home bucket, then waits in the response state until the result is taken.
// A request with hash zero or an unused type skips the probe. A probe visits at most
// every bucket of the table once. A new request is taken only after the response to the
// last one has been handed over. After reset and after every size_log write, a clearing
// pass writes all MAX_BUCKETS buckets before requests are taken.
`include "linear_probe_hash_table_defines.svh"
module linear_probe_hash_table
   import lpht_pkg::*;
#(
   parameter int unsigned MAX_BUCKETS = 1024,
   parameter int unsigned DATA_BITS   = 32,
   parameter int unsigned EPOCH_BITS  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   lpht_req_if.sink              req,
   lpht_rsp_if.source            rsp
);
   localparam int unsigned IDX_W  = $clog2(MAX_BUCKETS);
   localparam int unsigned LOG_MAX = IDX_W;
   localparam int unsigned CNT_W  = IDX_W + 1;
   localparam int unsigned WORD_W = HASH_W + DATA_BITS + EPOCH_BITS;
   localparam int unsigned LOG_RESET = (int'(SIZE_LOG_RESET) > int'(LOG_MAX)) ? LOG_MAX
                                                                             : SIZE_LOG_RESET;
   localparam logic [IDX_W-1:0] MASK_RESET = IDX_W'((32'd1 << LOG_RESET) - 32'd1);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_CHECK, ST_RESP
   } state_type;

   state_type                state_ff, state_in;
   logic [SIZE_LOG_W-1:0]    size_log_ff, size_log_in;
   logic [COUNT_W-1:0]       used_limit_ff, used_limit_in;
   logic [IDX_W-1:0]         mask_ff, mask_in;
   logic [IDX_W-1:0]         ix_ff, ix_in;
   logic [CNT_W-1:0]         visits_ff, visits_in;
   logic [EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic [COUNT_W-1:0]       claimed_ff, claimed_in;
   logic [COUNT_W-1:0]       entries_ff, entries_in;
   logic [REQ_TYPE_W-1:0]    op_ff, op_in;
   logic [HASH_W-1:0]        hash_ff, hash_in;
   logic [DATA_BITS-1:0]     value_ff, value_in;
   logic                     found_ff, found_in;
   logic [VALUE_W-1:0]       old_ff, old_in;
   logic                     added_ff, added_in;
   logic                     full_ff, full_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic [WORD_W-1:0]        wr_data, rd_data;
   logic [HASH_W-1:0]        rd_hash;
   logic [DATA_BITS-1:0]     rd_value;
   logic [EPOCH_BITS-1:0]    rd_epoch;
   logic [EPOCH_BITS-1:0]    epoch_next;
   logic [3:0]               lg_eff;
   logic [IDX_W-1:0]         mask_calc;
   logic                     size_wr;

   lpht_ram #(.WIDTH(WORD_W), .DEPTH(MAX_BUCKETS)) u_buckets (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ix_ff),
      .rd_data (rd_data)
   );

   assign rd_hash  = rd_data[WORD_W-1 -: HASH_W];
   assign rd_value = rd_data[EPOCH_BITS +: DATA_BITS];
   assign rd_epoch = rd_data[EPOCH_BITS-1:0];
   assign size_wr  = csr_wr_en && (csr_index == CSR_SIZE_LOG);

   always_comb begin
      lg_eff = (csr_wr_data[SIZE_LOG_W-1:0] < SIZE_LOG_MIN) ? SIZE_LOG_MIN
                                                             : csr_wr_data[SIZE_LOG_W-1:0];
      if (32'(lg_eff) > LOG_MAX) begin
         lg_eff = 4'(LOG_MAX);
      end
      mask_calc = IDX_W'((CNT_W'(1) << lg_eff) - CNT_W'(1));
      epoch_next = epoch_ff + EPOCH_BITS'(1);
      if (epoch_next == '0) begin
         epoch_next = EPOCH_BITS'(1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      size_log_in   = size_log_ff;
      used_limit_in = used_limit_ff;
      mask_in       = mask_ff;
      ix_in         = ix_ff;
      visits_in     = visits_ff;
      epoch_in      = epoch_ff;
      claimed_in    = claimed_ff;
      entries_in    = entries_ff;
      op_in         = op_ff;
      hash_in       = hash_ff;
      value_in      = value_ff;
      found_in      = found_ff;
      old_in        = old_ff;
      added_in      = added_ff;
      full_in       = full_ff;
      wr_en         = 1'b0;
      wr_addr       = ix_ff;
      wr_data       = rd_data;
      req.ready     = (state_ff == ST_IDLE);
      rsp.valid     = (state_ff == ST_RESP);

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            ix_in   = ix_ff + IDX_W'(1);
            if (ix_ff == IDX_W'(MAX_BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               op_in     = req.req_type;
               hash_in   = req.key_hash;
               value_in  = DATA_BITS'(req.new_value);
               ix_in     = req.key_hash[IDX_W-1:0] & mask_ff;
               visits_in = '0;
               found_in  = 1'b0;
               old_in    = '0;
               added_in  = 1'b0;
               full_in   = 1'b0;
               if (req.key_hash == '0 || req.req_type > OP_REMOVE) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_RESP;
            if (rd_hash == hash_ff) begin
               found_in = (rd_epoch != '0);
               old_in   = VALUE_W'(rd_value);
               if (rd_epoch != '0) begin
                  case (op_ff)
                     OP_PUT, OP_REPLACE: begin
                        wr_en   = 1'b1;
                        wr_data = {rd_hash, value_ff, rd_epoch};
                     end
                     OP_REMOVE: begin
                        wr_en      = 1'b1;
                        wr_data    = {rd_hash, DATA_BITS'(0), EPOCH_BITS'(0)};
                        entries_in = entries_ff - COUNT_W'(1);
                     end
                     default: ;
                  endcase
               end else if (op_ff == OP_PUT || op_ff == OP_ADD) begin
                  wr_en      = 1'b1;
                  wr_data    = {rd_hash, value_ff, epoch_ff};
                  epoch_in   = epoch_next;
                  entries_in = entries_ff + COUNT_W'(1);
                  added_in   = (op_ff == OP_ADD);
               end
            end else if (rd_hash == '0) begin
               if (op_ff == OP_PUT || op_ff == OP_ADD) begin
                  if (claimed_ff >= used_limit_ff) begin
                     full_in = 1'b1;
                  end else begin
                     wr_en      = 1'b1;
                     wr_data    = {hash_ff, value_ff, epoch_ff};
                     epoch_in   = epoch_next;
                     claimed_in = claimed_ff + COUNT_W'(1);
                     entries_in = entries_ff + COUNT_W'(1);
                     added_in   = (op_ff == OP_ADD);
                  end
               end
            end else if (visits_ff == CNT_W'({1'b0, mask_ff})) begin
               full_in = (op_ff == OP_PUT || op_ff == OP_ADD);
            end else begin
               ix_in     = (ix_ff + IDX_W'(1)) & mask_ff;
               visits_in = visits_ff + CNT_W'(1);
               state_in  = ST_READ;
            end
         end
         ST_RESP: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      if (csr_wr_en) begin
         if (csr_index == CSR_USED_LIMIT) begin
            used_limit_in = COUNT_W'(csr_wr_data);
         end else begin
            size_log_in = csr_wr_data[SIZE_LOG_W-1:0];
            mask_in     = mask_calc;
            state_in    = ST_CLEAR;
            ix_in       = '0;
            epoch_in    = EPOCH_BITS'(1);
            claimed_in  = '0;
            entries_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         size_log_ff   <= SIZE_LOG_RESET;
         used_limit_ff <= USED_LIMIT_RESET;
         mask_ff       <= MASK_RESET;
         ix_ff         <= '0;
         visits_ff     <= '0;
         epoch_ff      <= EPOCH_BITS'(1);
         claimed_ff    <= '0;
         entries_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         size_log_ff   <= size_log_in;
         used_limit_ff <= used_limit_in;
         mask_ff       <= mask_in;
         ix_ff         <= ix_in;
         visits_ff     <= visits_in;
         epoch_ff      <= epoch_in;
         claimed_ff    <= claimed_in;
         entries_ff    <= entries_in;
      end
      op_ff    <= op_in;
      hash_ff  <= hash_in;
      value_ff <= value_in;
      found_ff <= found_in;
      old_ff   <= old_in;
      added_ff <= added_in;
      full_ff  <= full_in;
   end

   assign rsp.found      = found_ff;
   assign rsp.old_value  = old_ff;
   assign rsp.add_done   = added_ff;
   assign rsp.status     = full_ff;
   assign rsp.live_count = entries_ff;

   `LPHT_ASSERT_IMPL(a_live_le_claimed, clock, reset, 1'b1, entries_ff <= claimed_ff,
      "live entries exceed claimed buckets")
   `LPHT_ASSERT_IMPL(a_epoch_nonzero, clock, reset, 1'b1, epoch_ff != '0,
      "epoch counter reached zero")
   `LPHT_ASSERT_NEXT(a_full_no_growth, clock, reset,
      state_ff == ST_CHECK && full_in && !csr_wr_en,
      claimed_ff == $past(claimed_ff), "refused insert changed claim count")
   `LPHT_ASSERT_IMPL(a_add_flags, clock, reset, rsp.valid && rsp.add_done,
      !rsp.found && !rsp.status, "add result flags inconsistent")
   `LPHT_ASSERT_IMPL(a_size_legal, clock, reset, 1'b1, size_wr || size_log_ff == size_log_ff,
      "size register undefined")
endmodule

// ===== tb/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 1ps
module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   localparam int unsigned TABLE_MAX   = 1024;
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam logic [REQ_TYPE_W-1:0] OP_SPARE_FIRST = OP_REMOVE + 3'd1;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] kind;
      logic [HASH_W-1:0]     key;
      logic [VALUE_W-1:0]    value;
   } request_t;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] old_value;
      logic               add_done;
      logic               status;
      logic [COUNT_W-1:0] live_count;
   } response_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lpht_req_if req_ch ();
   lpht_rsp_if rsp_ch ();

   linear_probe_hash_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   // Mirror of the bucket store.
   logic [HASH_W-1:0]  tbl_hash  [TABLE_MAX];
   logic [VALUE_W-1:0] tbl_value [TABLE_MAX];
   bit                 tbl_live  [TABLE_MAX];
   int unsigned        tbl_buckets;
   int unsigned        claimed;
   int unsigned        live_entries;
   int unsigned        claim_limit;
   logic [SIZE_LOG_W-1:0] cfg_size;

   request_t    pending_reqs[$];
   response_t   expected_rsps[$];
   logic [HASH_W-1:0] key_pool[16];
   int unsigned send_idle;
   int unsigned recv_idle;
   int unsigned errors;
   int unsigned cycles;
   int unsigned hold_cnt;
   bit          hold_on;
   bit          req_fire;
   response_t   seen;
   response_t   want;

   function automatic void clear_table();
      int unsigned lg;
      lg = (cfg_size < SIZE_LOG_MIN) ? SIZE_LOG_MIN : cfg_size;
      if (lg > 10) lg = 10;
      tbl_buckets = 1 << lg;
      for (int i = 0; i < TABLE_MAX; i++) begin
         tbl_hash[i] = '0;
         tbl_value[i] = '0;
         tbl_live[i] = 1'b0;
      end
      claimed = 0;
      live_entries = 0;
   endfunction

   function automatic response_t lookup_and_update(request_t r);
      response_t res;
      int ix, hit, free_ix;
      bit full;
      res = '0;
      full = 1'b0;
      if (r.key != '0 && r.kind <= OP_REMOVE) begin
         hit = -1;
         free_ix = -1;
         ix = int'(r.key[15:0]) & (tbl_buckets - 1);
         for (int i = 0; i < tbl_buckets; i++) begin
            if (tbl_hash[ix] == '0) begin
               free_ix = ix;
               break;
            end
            if (tbl_hash[ix] == r.key) begin
               hit = ix;
               break;
            end
            ix = (ix + 1) & (tbl_buckets - 1);
         end
         if (hit >= 0 && tbl_live[hit]) begin
            res.found = 1'b1;
            res.old_value = tbl_value[hit];
         end
         if (r.kind == OP_PUT || r.kind == OP_ADD) begin
            if (hit < 0) begin
               if (free_ix < 0 || claimed >= claim_limit) begin
                  full = 1'b1;
               end else begin
                  hit = free_ix;
                  tbl_hash[hit] = r.key;
                  claimed++;
               end
            end
            if (!full) begin
               if (res.found) begin
                  if (r.kind == OP_PUT) tbl_value[hit] = r.value;
               end else begin
                  tbl_value[hit] = r.value;
                  tbl_live[hit] = 1'b1;
                  live_entries++;
                  if (r.kind == OP_ADD) res.add_done = 1'b1;
               end
            end
         end else if (r.kind == OP_REPLACE) begin
            if (res.found) tbl_value[hit] = r.value;
         end else if (r.kind == OP_REMOVE) begin
            if (res.found) begin
               tbl_live[hit] = 1'b0;
               tbl_value[hit] = '0;
               live_entries--;
            end
         end
      end
      res.status = full;
      res.live_count = live_entries[COUNT_W-1:0];
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_SIZE_LOG) begin
         cfg_size = data[SIZE_LOG_W-1:0];
         clear_table();
      end else begin
         claim_limit = data;
      end
   endtask

   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_ch.valid);
      repeat (8) @(posedge clock);
   endtask

   task automatic push_req(logic [REQ_TYPE_W-1:0] kind, logic [HASH_W-1:0] key,
                           logic [VALUE_W-1:0] value);
      request_t r;
      r.kind = kind;
      r.key = key;
      r.value = value;
      pending_reqs.push_back(r);
   endtask

   task automatic push_random(int unsigned count);
      logic [REQ_TYPE_W-1:0] kind;
      logic [HASH_W-1:0] key;
      int unsigned pick;
      for (int i = 0; i < 16; i++) begin
         key_pool[i] = {$urandom, $urandom};
         if (i % 2 == 1) key_pool[i][9:0] = key_pool[i-1][9:0];
         if (key_pool[i] == '0) key_pool[i] = 64'd1;
      end
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 85) key = key_pool[$urandom_range(15)];
         else if (pick < 95) key = {$urandom, $urandom};
         else key = '0;
         if ($urandom_range(9) == 0) kind = $urandom_range(7, OP_SPARE_FIRST);
         else kind = $urandom_range(OP_REMOVE, OP_GET);
         push_req(kind, key, $urandom);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Request driver.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         req_ch.valid <= 1'b1;
      end else if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
         request_t r;
         r = pending_reqs.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.req_type <= r.kind;
         req_ch.key_hash <= r.key;
         req_ch.new_value <= r.value;
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Response receiver, including one long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
         rsp_ch.ready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // Monitor: prediction on each accepted request, comparison on each response.
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         req_fire <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            expected_rsps.push_back(lookup_and_update('{req_ch.req_type, req_ch.key_hash,
                                                        req_ch.new_value}));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.found, rsp_ch.old_value, rsp_ch.add_done, rsp_ch.status,
                     rsp_ch.live_count};
            if (expected_rsps.size() == 0) begin
               $error("Response transfer with no request outstanding");
               errors++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("found", want.found, seen.found);
               check_field("old_value", want.old_value, seen.old_value);
               check_field("add_done", want.add_done, seen.add_done);
               check_field("status", want.status, seen.status);
               check_field("live_count", want.live_count, seen.live_count);
            end
         end
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      hold_cnt = 0;
      hold_on = 1'b0;
      send_idle = 29;
      recv_idle = 86;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_SIZE_LOG;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = OP_GET;
      req_ch.key_hash = '0;
      req_ch.new_value = '0;
      rsp_ch.ready = 1'b0;
      cfg_size = SIZE_LOG_RESET;
      claim_limit = USED_LIMIT_RESET;
      clear_table();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Small table with a low claim limit: hits, misses, reuse and refusals.
      csr_write(CSR_USED_LIMIT, 11'd3);
      csr_write(CSR_SIZE_LOG, SIZE_LOG_MIN);
      push_req(OP_GET, 64'd1, 32'd0);
      push_req(OP_PUT, 64'd1, 32'd0);
      push_req(OP_PUT, 64'd1, 32'hFFFF_FFFF);
      push_req(OP_REPLACE, 64'd9, 32'h1234_5678);
      push_req(OP_ADD, 64'd9, 32'd5);
      push_req(OP_ADD, 64'd9, 32'd7);
      push_req(OP_REPLACE, 64'd9, 32'hAAAA_5555);
      push_req(OP_REMOVE, 64'd1, 32'd0);
      push_req(OP_REMOVE, 64'd1, 32'd0);
      push_req(OP_GET, 64'd1, 32'd0);
      push_req(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0001);
      push_req(OP_PUT, 64'd2, 32'd11);
      push_req(OP_ADD, 64'd4, 32'd12);
      push_req(OP_PUT, 64'd1, 32'd13);
      push_req(OP_PUT, 64'd0, 32'd14);
      push_req(OP_SPARE_FIRST, 64'd9, 32'd15);
      push_req(OP_SPARE_FIRST + 3'd1, 64'd9, 32'd16);
      push_req(3'd7, 64'd9, 32'd17);
      push_req(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
      wait_idle();

      // Size below the minimum, no claim limit: fill every bucket.
      csr_write(CSR_USED_LIMIT, 11'd2047);
      csr_write(CSR_SIZE_LOG, 4'd0);
      for (int i = 1; i <= 9; i++) push_req(OP_PUT, 64'(i * 8 + 3), $urandom);
      push_req(OP_GET, 64'd5, 32'd0);
      wait_idle();

      csr_write(CSR_SIZE_LOG, 4'd4);
      csr_write(CSR_USED_LIMIT, 11'd12);
      push_random(250);
      wait_idle();

      send_idle = 86;
      recv_idle = 29;
      csr_write(CSR_SIZE_LOG, 4'd15);
      csr_write(CSR_USED_LIMIT, 11'd1024);
      push_random(250);
      wait_idle();

      send_idle = 0;
      recv_idle = 0;
      csr_write(CSR_SIZE_LOG, 4'd5);
      csr_write(CSR_USED_LIMIT, 11'd0);
      push_random(60);
      hold_on = 1'b1;
      wait_idle();

      csr_write(CSR_SIZE_LOG, SIZE_LOG_MIN);
      csr_write(CSR_USED_LIMIT, 11'd2047);
      push_random(240);
      wait_idle();

      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
